>>> rtl/grbfw_pkg.sv
// Shared types and constants for the Gaussian RBF weight core.
// Used by the front, queue, back and top-level files; depends on nothing.

package grbfw_pkg;

  // Number of terms in the Horner series for exp(-f).
  localparam int unsigned SERIES_TERMS = 9;
  // Largest integer part of the argument below the cut-off.
  localparam int unsigned SCALE_STEPS  = 11;
  localparam int unsigned INT_W        = 4;
  localparam int unsigned FRAC_W       = 16;
  // Q.32 accumulator, wide enough to hold exactly 1.0.
  localparam int unsigned ACC_W        = 33;
  localparam int unsigned WEIGHT_W     = 17;
  localparam int unsigned REG_IDX_W    = 2;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [ACC_W-1:0] ONE_Q32    = 33'h1_0000_0000;
  localparam logic [31:0]      EXP_M1_Q32 = 32'd1580030169;
  localparam logic [19:0]      X_CUTOFF   = 20'd726818;
  localparam logic [31:0]      INV_R2_RST = 32'd65536;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X      = 2'd0,
    REG_CENTER_Y      = 2'd1,
    REG_CENTER_Z      = 2'd2,
    REG_INV_RADIUS_SQ = 2'd3
  } reg_idx_e;

  // Classified argument handed from the front to the back.
  typedef struct packed {
    logic              kill;
    logic [INT_W-1:0]  n;
    logic [FRAC_W-1:0] f;
  } arg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/grbfw_front.sv
// Front end: configuration registers, squared distance and scaling by 1/r^2.
// Produces the integer and fractional parts of the exponent; uses grbfw_pkg.

module grbfw_front
  import grbfw_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32,
  localparam int unsigned CFG_W = (COORD_BITS > 32) ? COORD_BITS : 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] point_z_i,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  q_status_t             q_status_i,
  output logic                  q_push_o,
  output arg_t                  q_entry_o
);

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NSTG     = 6;
  localparam int unsigned DIFF_W   = COORD_BITS + 1;
  localparam int unsigned TERM_W   = 48;
  localparam int unsigned D2_W     = 50;
  localparam int unsigned SPLIT    = 25;
  localparam int unsigned PP_W     = SPLIT + 32;
  localparam int unsigned PROD_W   = D2_W + 32;

  logic [COORD_BITS-1:0] center_q [NUM_AXES];
  logic [31:0]           inv_q;
  logic [COORD_BITS-1:0] pt [NUM_AXES];

  logic [NSTG-1:0]          vld_q;
  logic                     en;
  logic                     accept;

  logic signed [DIFF_W-1:0] diff_d [NUM_AXES];
  logic signed [DIFF_W-1:0] diff_q [NUM_AXES];
  logic [DIFF_W-1:0]        mag [NUM_AXES];
  logic [63:0]              mag64 [NUM_AXES];
  logic [NUM_AXES-1:0]      big;
  logic [31:0]              m_q [NUM_AXES];
  logic                     sat2_q;
  logic [63:0]              sq [NUM_AXES];
  logic [TERM_W-1:0]        term_q [NUM_AXES];
  logic                     sat3_q;
  logic [D2_W-1:0]          d2_q;
  logic                     sat4_q;
  logic [PP_W-1:0]          plo_q;
  logic [PP_W-1:0]          phi_q;
  logic                     kill5_q;
  logic [PROD_W-1:0]        prod;
  logic                     x_big;
  arg_t                     entry_d;
  arg_t                     entry_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        center_q[a] <= '0;
      end
      inv_q <= INV_R2_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X:      center_q[0] <= cfg_wdata_i[COORD_BITS-1:0];
        REG_CENTER_Y:      center_q[1] <= cfg_wdata_i[COORD_BITS-1:0];
        REG_CENTER_Z:      center_q[2] <= cfg_wdata_i[COORD_BITS-1:0];
        REG_INV_RADIUS_SQ: inv_q       <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // The whole front moves together; it only holds when its last stage
  // cannot transfer into a full queue.
  assign en       = !vld_q[NSTG-1] || !q_status_i.full;
  assign full_o   = !en;
  assign accept   = push_i && en;
  assign q_push_o = vld_q[NSTG-1] && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff_d[a] = DIFF_W'($signed(pt[a])) - DIFF_W'($signed(center_q[a]));
      mag[a]    = diff_q[a][DIFF_W-1] ? DIFF_W'(-diff_q[a]) : DIFF_W'(diff_q[a]);
      mag64[a]  = 64'(mag[a]);
      big[a]    = |mag64[a][63:32];
      sq[a]     = 64'(m_q[a]) * 64'(m_q[a]);
    end
  end

  // The split product is recombined here; anything at or past the cut-off,
  // including a product of more than 36 bits, gives a zero weight.
  always_comb begin
    prod         = (PROD_W'(phi_q) << SPLIT) + PROD_W'(plo_q);
    x_big        = (|prod[PROD_W-1:36]) || (prod[35:16] >= X_CUTOFF);
    entry_d.kill = kill5_q || x_big;
    entry_d.n    = prod[35:32];
    entry_d.f    = prod[31:16];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        diff_q[a] <= diff_d[a];
        m_q[a]    <= mag64[a][31:0];
        term_q[a] <= sq[a][63:16];
      end
      sat2_q  <= |big;
      sat3_q  <= sat2_q;
      d2_q    <= D2_W'(term_q[0]) + D2_W'(term_q[1]) + D2_W'(term_q[2]);
      sat4_q  <= sat3_q;
      plo_q   <= PP_W'(d2_q[SPLIT-1:0]) * PP_W'(inv_q);
      phi_q   <= PP_W'(d2_q[D2_W-1:SPLIT]) * PP_W'(inv_q);
      kill5_q <= sat4_q && (inv_q != 32'd0);
      entry_q <= entry_d;
    end
  end

  assign q_entry_o = entry_q;

endmodule

>>> rtl/grbfw_fifo.sv
// Short register queue between the front and the back of the RBF core.
// Holds classified arguments; uses grbfw_pkg for the entry and status types.

module grbfw_fifo
  import grbfw_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  arg_t      data_i,
  input  logic      pop_i,
  output arg_t      data_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  arg_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> rtl/grbfw_back.sv
// Back end: exp(-f) by a pipelined Horner series, then n steps of exp(-1).
// Rounds to the Q1.16 weight and holds it for the result side; uses grbfw_pkg.

module grbfw_back
  import grbfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_status_t           q_status_i,
  input  arg_t                q_data_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [WEIGHT_W-1:0] weight_o
);

  localparam int unsigned SER_STG = 3 * SERIES_TERMS;
  localparam int unsigned NSTG    = SER_STG + SCALE_STEPS + 1;
  localparam int unsigned AF_W    = ACC_W + FRAC_W;

  logic [NSTG-1:0]     vld_q;
  arg_t                arg_q [NSTG-1];
  logic                en;

  logic [31:0]         t_q   [SERIES_TERMS];
  logic [31:0]         q0_q  [SERIES_TERMS];
  logic [31:0]         tc_q  [SERIES_TERMS];
  logic [ACC_W-1:0]    acc_q [SERIES_TERMS];
  logic [ACC_W-1:0]    sacc_q [SCALE_STEPS];

  logic [ACC_W:0]      rnd;
  logic [WEIGHT_W-1:0] weight_q;

  // A stalled result holds the whole back end in place.
  assign en      = !vld_q[NSTG-1] || pop_i;
  assign q_pop_o = en && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], !q_status_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      arg_q[0] <= q_data_i;
      for (int i = 1; i < NSTG - 1; i++) begin
        arg_q[i] <= arg_q[i-1];
      end
    end
  end

  // Each series term takes three stages: acc*f, an estimate of the quotient
  // by k through a reciprocal, and a one-step correction of that estimate.
  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam int unsigned K     = SERIES_TERMS - j;
    localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / K);

    logic [ACC_W-1:0]  acc_in;
    logic [FRAC_W-1:0] f_in;
    logic [AF_W-1:0]   mul_af;
    logic [63:0]       mul_tr;
    logic [31:0]       qk;
    logic [31:0]       rem;
    logic [31:0]       quo;

    if (j == 0) begin : g_first
      assign acc_in = ONE_Q32;
      assign f_in   = q_data_i.f;
    end else begin : g_next
      assign acc_in = acc_q[j-1];
      assign f_in   = arg_q[3*j-1].f;
    end

    assign mul_af = AF_W'(acc_in) * AF_W'(f_in);
    assign mul_tr = 64'(t_q[j]) * 64'(RECIP);
    assign qk     = 32'(64'(q0_q[j]) * 64'(K));
    assign rem    = tc_q[j] - qk;
    assign quo    = q0_q[j] + ((rem >= 32'(K)) ? 32'd1 : 32'd0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        t_q[j]   <= mul_af[47:16];
        q0_q[j]  <= mul_tr[63:32];
        tc_q[j]  <= t_q[j];
        acc_q[j] <= ONE_Q32 - ACC_W'(quo);
      end
    end
  end

  // One stage per possible unit of the integer part; a stage passes the
  // value through unchanged once the item's count is used up.
  for (genvar e = 0; e < SCALE_STEPS; e++) begin : g_scale
    logic [ACC_W-1:0] acc_in;
    logic [INT_W-1:0] n_in;
    logic [63:0]      mul;

    if (e == 0) begin : g_first
      assign acc_in = acc_q[SERIES_TERMS-1];
    end else begin : g_next
      assign acc_in = sacc_q[e-1];
    end

    assign n_in = arg_q[SER_STG+e-1].n;
    assign mul  = 64'(acc_in) * 64'(EXP_M1_Q32);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sacc_q[e] <= (n_in > INT_W'(e)) ? ACC_W'(mul[63:32]) : acc_in;
      end
    end
  end

  assign rnd = (ACC_W + 1)'(sacc_q[SCALE_STEPS-1]) + (ACC_W + 1)'(32'd32768);

  always_ff @(posedge clk_i) begin
    if (en) begin
      weight_q <= arg_q[NSTG-2].kill ? '0 : rnd[32:16];
    end
  end

  assign empty_o  = !vld_q[NSTG-1];
  assign weight_o = weight_q;

endmodule

>>> rtl/gaussian_rbf_weight_core.sv
// Top level of the Gaussian RBF weight core: front, queue and back.
// Depends on grbfw_pkg, grbfw_front, grbfw_fifo and grbfw_back.
//
//   Channel   Direction  Handshake          Payload
//   points    in         push / full        point_x_i, point_y_i, point_z_i
//   weights   out        empty / pop        weight_o
//   config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One point is taken every cycle while results are being popped; the
// pipelined series and exp(-1) steps of the back end set that rate.
// Reset clears the pipelines and the queue and restores the registers.
// A held result stalls the back end; the front keeps taking points until
// the four-entry queue between them is full and its own last stage holds a point, then raises full.

module gaussian_rbf_weight_core
  import grbfw_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32,
  localparam int unsigned CFG_W = (COORD_BITS > 32) ? COORD_BITS : 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] point_z_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [WEIGHT_W-1:0]   weight_o,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  arg_t      q_entry;
  arg_t      q_head;

  grbfw_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  grbfw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_entry),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .status_o(q_status)
  );

  grbfw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_status_i(q_status),
    .q_data_i  (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .weight_o  (weight_o)
  );

endmodule
